FILE: design/midi_step_arpeggiator_macros.svh
// Assertion macros shared by the arpeggiator checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef MIDI_STEP_ARPEGGIATOR_MACROS_SVH
`define MIDI_STEP_ARPEGGIATOR_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define MSA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define MSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define MSA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/msa_pkg.sv
// Package for the step arpeggiator: codes, defaults, command/status structs.
// No dependencies; used by every module of the block.
`default_nettype none

package msa_pkg;

    // Default parameter values
    localparam int BUFFER_DEPTH_DEF = 16;
    localparam int STEP_TICKS_DEF   = 6;
    localparam int NOTE_TOP_DEF     = 60;

    // Fixed field widths
    localparam int TICK_W     = 32;
    localparam int NOTE_W     = 7;
    localparam int CHAN_W     = 5;
    localparam int CV_W       = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Pitch wrap and DAC full scale
    localparam int PITCH_WRAP = 60;
    localparam int CV_FULL    = 4095;
    localparam int PITCH_W    = 6;

    // Divider: quotient bits retired per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = TICK_W / DIV_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_NOTE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_NOTE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_AMOUNT = 3'd6;

    // Configuration reset values
    localparam logic [4:0]        RST_MIDI_CHANNEL  = 5'd1;
    localparam logic              RST_RECORD_MODE   = 1'b1;
    localparam logic [7:0]        RST_GATE_LENGTH   = 8'd3;
    localparam logic signed [5:0] RST_TRANSPOSE     = 6'sd0;
    localparam logic [5:0]        RST_LOW_NOTE      = 6'd0;
    localparam logic [5:0]        RST_HIGH_NOTE     = 6'd60;
    localparam logic [2:0]        RST_RANDOM_AMOUNT = 3'd0;

    // Gate action codes
    localparam logic [1:0] GATE_NONE = 2'd0;
    localparam logic [1:0] GATE_LOW  = 2'd1;
    localparam logic [1:0] GATE_HIGH = 2'd2;

    // Number of random intervals
    localparam logic [2:0] DELTA_COUNT = 3'd5;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STEP,
        ST_DIV_INDEX,
        ST_READ,
        ST_PITCH,
        ST_CV,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       set_gate;
        logic [1:0] gate_code;
        logic       buf_write;
        logic       clear_count;
        logic       src_note;
        logic       buf_read;
        logic       div_start;
        logic       step_load;
        logic       load_pitch;
        logic       load_cv;
        logic       set_gate_start;
        logic       out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  note_ok;
        logic  chan_match;
        logic  record;
        logic  count_full;
        logic  count_zero;
        logic  div_done;
        logic  step_hit;
        logic  gate_off_hit;
        logic  pitch_in_range;
        logic  out_free;
    } dp_status_t;

    // Random interval by pick index; out-of-range picks give zero
    function automatic logic signed [4:0] delta_of(input logic [2:0] pick);
        logic signed [4:0] d;
        case (pick)
            3'd0:    d = -5'sd12;
            3'd1:    d = -5'sd5;
            3'd2:    d = 5'sd0;
            3'd3:    d = 5'sd7;
            3'd4:    d = 5'sd12;
            default: d = 5'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: design/msa_divider.sv
// Sequential restoring divider, DIV_BITS quotient bits per cycle; gives the remainder.
// Depends on msa_pkg for the dividend width and step counts.
`default_nettype none

module msa_divider #(
    parameter int DIV_W = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [msa_pkg::TICK_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]            divisor,
    output logic                             done,
    output logic [DIV_W-1:0]                 remainder
);

    localparam int CNT_W = (msa_pkg::DIV_STEPS > 1) ? $clog2(msa_pkg::DIV_STEPS) : 1;

    logic [msa_pkg::TICK_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [DIV_W-1:0]           dvs_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    // DIV_BITS compare-subtract steps per cycle
    always_comb
    begin
        logic [DIV_W:0]             trial;
        logic [DIV_W-1:0]           r;
        logic [msa_pkg::TICK_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        trial = '0;
        for (int k = 0; k < msa_pkg::DIV_BITS; k++)
        begin
            trial = {r, q[msa_pkg::TICK_W-1]};
            q = {q[msa_pkg::TICK_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
            r = trial[DIV_W-1:0];
        end
        quo_next = q;
        rem_next = r;
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(msa_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/msa_datapath.sv
// Datapath: config registers, item capture, note buffer, step reciprocal, divider,
// pitch/CV, output register. Depends on msa_pkg and msa_divider.
`default_nettype none

module msa_datapath #(
    parameter int BUFFER_DEPTH = msa_pkg::BUFFER_DEPTH_DEF,
    parameter int STEP_TICKS   = msa_pkg::STEP_TICKS_DEF,
    parameter int NOTE_TOP     = msa_pkg::NOTE_TOP_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
    // input item
    input  wire logic [1:0]                     kind,
    input  wire logic [msa_pkg::CHAN_W-1:0]     event_channel,
    input  wire logic [msa_pkg::NOTE_W-1:0]     note,
    input  wire logic [msa_pkg::TICK_W-1:0]     tick_count,
    input  wire logic [2:0]                     rand_chance,
    input  wire logic [2:0]                     rand_pick,
    // result item
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [1:0]                          gate_action,
    output logic                                cv_valid,
    output logic [msa_pkg::CV_W-1:0]            cv_value,
    // controller link
    input  wire msa_pkg::ctrl_cmd_t             cmd,
    output msa_pkg::dp_status_t                 status
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int DIV_W = CNT_W;

    // Reciprocal of the step period, exact for every 32-bit tick
    localparam int              STEP_L  = $clog2(STEP_TICKS);
    localparam int              STEP_SH = msa_pkg::TICK_W + STEP_L;
    localparam longint unsigned STEP_M  = ((64'd1 << STEP_SH) / 64'(STEP_TICKS)) + 64'd1;
    localparam logic [32:0]     STEP_MAGIC = 33'(STEP_M);
    localparam int              PROD_W  = msa_pkg::TICK_W + 33;

    // Configuration registers
    logic [4:0]        midi_channel_reg;
    logic              record_mode_reg;
    logic [7:0]        gate_length_reg;
    logic signed [5:0] transpose_reg;
    logic [5:0]        low_note_reg;
    logic [5:0]        high_note_reg;
    logic [2:0]        random_amount_reg;

    // Captured item
    logic [1:0]                 kind_reg;
    logic [msa_pkg::CHAN_W-1:0] chan_reg;
    logic [msa_pkg::NOTE_W-1:0] note_reg;
    logic [msa_pkg::TICK_W-1:0] tick_reg;
    logic [2:0]                 chance_reg;
    logic [2:0]                 pick_reg;

    // Block state
    logic [CNT_W-1:0]           count_reg;
    logic [msa_pkg::TICK_W-1:0] gate_start_reg;
    logic [msa_pkg::NOTE_W-1:0] note_mem [BUFFER_DEPTH];
    logic [msa_pkg::NOTE_W-1:0] pitch_src_reg;

    // Pitch and result
    logic [msa_pkg::PITCH_W-1:0] p_reg, p_next;
    logic [1:0]                  res_gate_reg;
    logic                        res_cv_valid_reg;
    logic [msa_pkg::CV_W-1:0]    res_cv_reg;

    // Output register
    logic                     out_valid_reg;
    logic [1:0]               out_gate_reg;
    logic                     out_cv_valid_reg;
    logic [msa_pkg::CV_W-1:0] out_cv_reg;

    // Step quotient
    logic [PROD_W-1:0]          step_prod;
    logic [msa_pkg::TICK_W-1:0] step_quo_reg, step_quo_next;

    // Divider link
    logic                       div_done;
    logic [DIV_W-1:0]           div_rem;

    logic [msa_pkg::CV_W-1:0] cv_lut [msa_pkg::PITCH_WRAP];

    // CV table, worked out at elaboration
    for (genvar gi = 0; gi < msa_pkg::PITCH_WRAP; gi++)
    begin : g_cv
        localparam int RAW = (2 * msa_pkg::CV_FULL * gi + NOTE_TOP) / (2 * NOTE_TOP);
        localparam int SAT = (RAW > msa_pkg::CV_FULL) ? msa_pkg::CV_FULL : RAW;
        assign cv_lut[gi] = msa_pkg::CV_W'(SAT);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_channel_reg  <= msa_pkg::RST_MIDI_CHANNEL;
            record_mode_reg   <= msa_pkg::RST_RECORD_MODE;
            gate_length_reg   <= msa_pkg::RST_GATE_LENGTH;
            transpose_reg     <= msa_pkg::RST_TRANSPOSE;
            low_note_reg      <= msa_pkg::RST_LOW_NOTE;
            high_note_reg     <= msa_pkg::RST_HIGH_NOTE;
            random_amount_reg <= msa_pkg::RST_RANDOM_AMOUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                msa_pkg::CFG_MIDI_CHANNEL:  midi_channel_reg  <= cfg_data[4:0];
                msa_pkg::CFG_RECORD_MODE:   record_mode_reg   <= cfg_data[0];
                msa_pkg::CFG_GATE_LENGTH:   gate_length_reg   <= cfg_data;
                msa_pkg::CFG_TRANSPOSE:     transpose_reg     <= $signed(cfg_data[5:0]);
                msa_pkg::CFG_LOW_NOTE:      low_note_reg      <= cfg_data[5:0];
                msa_pkg::CFG_HIGH_NOTE:     high_note_reg     <= cfg_data[5:0];
                msa_pkg::CFG_RANDOM_AMOUNT: random_amount_reg <= cfg_data[2:0];
                default:                    ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            chan_reg   <= event_channel;
            note_reg   <= note;
            tick_reg   <= tick_count;
            chance_reg <= rand_chance;
            pick_reg   <= rand_pick;
        end
    end

    // Fill count and gate start tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            gate_start_reg <= '0;
        end
        else
        begin
            if (cmd.clear_count)
                count_reg <= '0;
            else if (cmd.buf_write)
                count_reg <= count_reg + 1'b1;
            if (cmd.set_gate_start)
                gate_start_reg <= tick_reg;
        end
    end

    // Note buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
            note_mem[count_reg[IDX_W-1:0]] <= note_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_read)
            pitch_src_reg <= note_mem[div_rem[IDX_W-1:0]];
        else if (cmd.src_note)
            pitch_src_reg <= note_reg;
    end

    // Step quotient: tick / STEP_TICKS by reciprocal multiply and shift
    assign step_prod     = PROD_W'(tick_reg) * PROD_W'(STEP_MAGIC);
    assign step_quo_next = msa_pkg::TICK_W'(step_prod >> STEP_SH);

    always_ff @(posedge clk)
    begin
        if (cmd.step_load)
            step_quo_reg <= step_quo_next;
    end

    // Step index: quotient mod fill count
    msa_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (step_quo_reg),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Output pitch: add offsets, then wrap into the PITCH_WRAP span, 0 to 59
    always_comb
    begin
        logic signed [4:0] delta;
        logic signed [8:0] sum;
        logic [7:0]        u;
        if (chance_reg < random_amount_reg && pick_reg < msa_pkg::DELTA_COUNT)
            delta = msa_pkg::delta_of(pick_reg);
        else
            delta = 5'sd0;
        sum = $signed({2'b00, pitch_src_reg}) + 9'sd60 + 9'(transpose_reg) + 9'(delta);
        u = sum[7:0];
        if (u >= 8'(3 * msa_pkg::PITCH_WRAP))
            p_next = msa_pkg::PITCH_W'(u - 8'(3 * msa_pkg::PITCH_WRAP));
        else if (u >= 8'(2 * msa_pkg::PITCH_WRAP))
            p_next = msa_pkg::PITCH_W'(u - 8'(2 * msa_pkg::PITCH_WRAP));
        else if (u >= 8'(msa_pkg::PITCH_WRAP))
            p_next = msa_pkg::PITCH_W'(u - 8'(msa_pkg::PITCH_WRAP));
        else
            p_next = msa_pkg::PITCH_W'(u);
    end

    // Pitch and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_pitch)
            p_reg <= p_next;
        if (cmd.capture)
        begin
            res_gate_reg     <= msa_pkg::GATE_NONE;
            res_cv_valid_reg <= 1'b0;
            res_cv_reg       <= '0;
        end
        else
        begin
            if (cmd.set_gate)
                res_gate_reg <= cmd.gate_code;
            if (cmd.load_cv)
            begin
                res_cv_valid_reg <= 1'b1;
                res_cv_reg       <= cv_lut[p_reg];
            end
        end
    end

    // Output register: holds a transaction until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_gate_reg     <= res_gate_reg;
            out_cv_valid_reg <= res_cv_valid_reg;
            out_cv_reg       <= res_cv_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign gate_action = out_gate_reg;
    assign cv_valid    = out_cv_valid_reg;
    assign cv_value    = out_cv_reg;

    // Status toward the controller
    always_comb
    begin
        status.kind       = msa_pkg::kind_t'(kind_reg);
        status.chan_match = (chan_reg == midi_channel_reg);
        status.note_ok    = status.chan_match
                            && (note_reg <= msa_pkg::NOTE_W'(NOTE_TOP))
                            && ({1'b0, low_note_reg} <= note_reg);
        status.record     = record_mode_reg;
        status.count_full = (count_reg >= CNT_W'(BUFFER_DEPTH));
        status.count_zero = (count_reg == '0);
        status.div_done   = div_done;
        status.step_hit   = (tick_reg == msa_pkg::TICK_W'(step_quo_reg
                                                          * msa_pkg::TICK_W'(STEP_TICKS)));
        status.gate_off_hit = ((tick_reg - gate_start_reg)
                               == msa_pkg::TICK_W'(gate_length_reg));
        status.pitch_in_range = ({1'b0, low_note_reg} <= pitch_src_reg)
                                && (pitch_src_reg < {1'b0, high_note_reg});
        status.out_free   = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

FILE: design/msa_ctrl.sv
// Controller state machine: sequences one item through the datapath.
// Depends on msa_pkg for states, command and status structs.
`default_nettype none

module msa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire msa_pkg::dp_status_t status,
    output msa_pkg::ctrl_cmd_t       cmd
);

    msa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= msa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != msa_pkg::ST_IDLE);
        case (state_reg)
            msa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = msa_pkg::ST_DECODE;
                end
            end
            msa_pkg::ST_DECODE:
            begin
                state_next = msa_pkg::ST_FINISH;
                case (status.kind)
                    msa_pkg::KIND_NOTE_ON:
                    begin
                        if (status.note_ok)
                        begin
                            cmd.set_gate  = 1'b1;
                            cmd.gate_code = msa_pkg::GATE_HIGH;
                            cmd.src_note  = 1'b1;
                            cmd.buf_write = status.record && !status.count_full;
                            state_next    = msa_pkg::ST_PITCH;
                        end
                    end
                    msa_pkg::KIND_NOTE_OFF:
                    begin
                        if (status.chan_match)
                        begin
                            cmd.set_gate  = 1'b1;
                            cmd.gate_code = msa_pkg::GATE_LOW;
                        end
                    end
                    msa_pkg::KIND_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                        cmd.set_gate    = 1'b1;
                        cmd.gate_code   = msa_pkg::GATE_LOW;
                    end
                    msa_pkg::KIND_TICK:
                    begin
                        if (!status.record && !status.count_zero)
                        begin
                            cmd.step_load = 1'b1;
                            state_next    = msa_pkg::ST_STEP;
                        end
                    end
                    default: ;
                endcase
            end
            msa_pkg::ST_STEP:
            begin
                // tick on a step boundary plays, otherwise test the gate-off
                if (status.step_hit)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = msa_pkg::ST_DIV_INDEX;
                end
                else
                begin
                    if (status.gate_off_hit)
                    begin
                        cmd.set_gate  = 1'b1;
                        cmd.gate_code = msa_pkg::GATE_LOW;
                    end
                    state_next = msa_pkg::ST_FINISH;
                end
            end
            msa_pkg::ST_DIV_INDEX:
            begin
                if (status.div_done)
                begin
                    cmd.buf_read = 1'b1;
                    state_next   = msa_pkg::ST_READ;
                end
            end
            msa_pkg::ST_READ:
            begin
                if (status.pitch_in_range)
                begin
                    cmd.set_gate       = 1'b1;
                    cmd.gate_code      = msa_pkg::GATE_HIGH;
                    cmd.set_gate_start = 1'b1;
                    state_next         = msa_pkg::ST_PITCH;
                end
                else
                    state_next = msa_pkg::ST_FINISH;
            end
            msa_pkg::ST_PITCH:
            begin
                cmd.load_pitch = 1'b1;
                state_next     = msa_pkg::ST_CV;
            end
            msa_pkg::ST_CV:
            begin
                cmd.load_cv = 1'b1;
                state_next  = msa_pkg::ST_FINISH;
            end
            msa_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = msa_pkg::ST_IDLE;
                end
            end
            default:
                state_next = msa_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/midi_step_arpeggiator.sv
// Top level of the MIDI step arpeggiator: controller plus datapath.
// Depends on msa_pkg, msa_ctrl, msa_datapath (and msa_divider below it).
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   in      | in_valid / in_stall   | kind, event_channel, note, tick_count,
//           |                       | rand_chance, rand_pick
//   out     | out_valid / out_stall | gate_action, cv_valid, cv_value
//   cfg     | cfg_write             | cfg_index, cfg_data
//
// Path per item: an accepted note-on goes through decode, pitch, CV and finish;
// note-off, clear, refused note or idle tick through decode and finish; off-step tick
// through decode, step and finish. Step ticks take tick/STEP_TICKS by reciprocal
// multiply, then quotient mod fill count in a divider retiring 4 bits a cycle.
// One item in flight; in_stall is high from accept until the result enters the
// output register, which holds it under out_stall. Async reset, no clearing pass.
`default_nettype none

module midi_step_arpeggiator #(
    parameter int BUFFER_DEPTH = msa_pkg::BUFFER_DEPTH_DEF,
    parameter int STEP_TICKS   = msa_pkg::STEP_TICKS_DEF,
    parameter int NOTE_TOP     = msa_pkg::NOTE_TOP_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     kind,
    input  wire logic [msa_pkg::CHAN_W-1:0]     event_channel,
    input  wire logic [msa_pkg::NOTE_W-1:0]     note,
    input  wire logic [msa_pkg::TICK_W-1:0]     tick_count,
    input  wire logic [2:0]                     rand_chance,
    input  wire logic [2:0]                     rand_pick,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          gate_action,
    output logic                                cv_valid,
    output logic [msa_pkg::CV_W-1:0]            cv_value
);

    msa_pkg::ctrl_cmd_t  cmd;
    msa_pkg::dp_status_t status;

    msa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    msa_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .STEP_TICKS   (STEP_TICKS),
        .NOTE_TOP     (NOTE_TOP)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .event_channel (event_channel),
        .note          (note),
        .tick_count    (tick_count),
        .rand_chance   (rand_chance),
        .rand_pick     (rand_pick),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .gate_action   (gate_action),
        .cv_valid      (cv_valid),
        .cv_value      (cv_value),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

FILE: design/msa_checker.sv
// Port-level checker for the arpeggiator, bound to the top level.
// Depends on msa_pkg and midi_step_arpeggiator_macros.svh.
`default_nettype none
`include "midi_step_arpeggiator_macros.svh"

module msa_port_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [1:0]                 gate_action,
    input wire logic                       cv_valid,
    input wire logic [msa_pkg::CV_W-1:0]   cv_value
);

    // A stalled result stays offered
    `MSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

    // One item in flight: an accepted transaction stalls the input next cycle
    `MSA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second item taken early")

    // A CV word always comes with the gate raised
    `MSA_ASSERT_IMPLY(a_cv_gate, out_valid && cv_valid, gate_action == msa_pkg::GATE_HIGH,
        "CV sent without gate high")

    // No CV means a zero word
    `MSA_ASSERT_IMPLY(a_cv_zero, out_valid && !cv_valid, cv_value == '0,
        "stale CV word on a result without CV")

    // Gate code three is never produced
    `MSA_ASSERT_IMPLY(a_gate_code, out_valid, gate_action != 2'd3, "undefined gate code")

endmodule

bind midi_step_arpeggiator msa_port_checker u_msa_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .gate_action (gate_action),
    .cv_valid    (cv_valid),
    .cv_value    (cv_value)
);

`default_nettype wire

FILE: bench/msa_checker.sv
`timescale 1ns / 1ps
// Checker for midi_step_arpeggiator: follows register writes, predicts one result
// per accepted input transaction and compares it with the output channel.
// Depends on msa_pkg for widths, register indexes, gate codes and kinds.
module msa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [msa_pkg::CHAN_W-1:0]     event_channel,
    input  logic [msa_pkg::NOTE_W-1:0]     note,
    input  logic [msa_pkg::TICK_W-1:0]     tick_count,
    input  logic [2:0]                     rand_chance,
    input  logic [2:0]                     rand_pick,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [1:0]                     gate_action,
    input  logic                           cv_valid,
    input  logic [msa_pkg::CV_W-1:0]       cv_value,
    output int                             error_count,
    output int                             pending_count,
    output int                             checked_count,
    output int                             cv_count
);
    import msa_pkg::*;

    localparam logic [TICK_W-1:0] STEP_LEN = TICK_W'(STEP_TICKS_DEF);

    typedef struct packed {
        logic [1:0]      gate;
        logic            cv_on;
        logic [CV_W-1:0] cv;
    } arp_result_t;

    // Register copies
    logic [CHAN_W-1:0]  chan_cfg;
    logic               record_cfg;
    logic [7:0]         gate_len_cfg;
    logic signed [5:0]  transpose_cfg;
    logic [5:0]         low_cfg;
    logic [5:0]         high_cfg;
    logic [2:0]         rnd_amount_cfg;

    // Arpeggio state
    logic [NOTE_W-1:0]  note_mem [BUFFER_DEPTH_DEF];
    logic [4:0]         fill;
    logic [TICK_W-1:0]  gate_start;

    arp_result_t        expected_q [$];
    int                 errs;
    int                 checked;
    int                 cvs;

    // Semitone jump for a pick index; picks past the table add nothing
    function automatic int interval_for(input logic [2:0] pick);
        int jump;
        case (pick)
            3'd0:    jump = -12;
            3'd1:    jump = -5;
            3'd3:    jump = 7;
            3'd4:    jump = 12;
            default: jump = 0;
        endcase
        return jump;
    endfunction

    // Pitch after transpose and random jump, wrapped to 60, scaled to the DAC
    function automatic logic [CV_W-1:0] pitch_to_cv(input logic [NOTE_W-1:0] pitch,
                                                    input logic [2:0] chance,
                                                    input logic [2:0] pick);
        int sum;
        int wrapped;
        int word;
        sum = int'(pitch) + PITCH_WRAP + int'(transpose_cfg);
        if (chance < rnd_amount_cfg)
            sum = sum + interval_for(pick);
        wrapped = ((sum % PITCH_WRAP) + PITCH_WRAP) % PITCH_WRAP;
        word = (2 * CV_FULL * wrapped + NOTE_TOP_DEF) / (2 * NOTE_TOP_DEF);
        if (word > CV_FULL)
            word = CV_FULL;
        return CV_W'(word);
    endfunction

    // Advance the arpeggio state by one transaction and return its result
    function automatic arp_result_t next_result(input kind_t k,
                                                input logic [CHAN_W-1:0] chan,
                                                input logic [NOTE_W-1:0] pitch,
                                                input logic [TICK_W-1:0] tick,
                                                input logic [2:0] chance,
                                                input logic [2:0] pick);
        arp_result_t r;
        logic [TICK_W-1:0] slot;
        logic [NOTE_W-1:0] stored;
        r = '0;
        r.gate = GATE_NONE;
        case (k)
            KIND_NOTE_ON:
            begin
                if (chan == chan_cfg && pitch <= NOTE_TOP_DEF && pitch >= low_cfg)
                begin
                    r.gate = GATE_HIGH;
                    // full buffer: note still sounds but is not stored
                    if (record_cfg && fill < BUFFER_DEPTH_DEF)
                    begin
                        note_mem[fill[3:0]] = pitch;
                        fill = fill + 5'd1;
                    end
                    r.cv_on = 1'b1;
                    r.cv = pitch_to_cv(pitch, chance, pick);
                end
            end
            KIND_NOTE_OFF:
            begin
                if (chan == chan_cfg)
                    r.gate = GATE_LOW;
            end
            KIND_CLEAR:
            begin
                fill = '0;
                r.gate = GATE_LOW;
            end
            default:
            begin
                // ticks only act in playback with something buffered
                if (!record_cfg && fill != 0)
                begin
                    if (tick % STEP_LEN == 0)
                    begin
                        slot = (tick / STEP_LEN) % TICK_W'(fill);
                        stored = note_mem[slot[3:0]];
                        if (stored >= low_cfg && stored < high_cfg)
                        begin
                            r.gate = GATE_HIGH;
                            r.cv_on = 1'b1;
                            r.cv = pitch_to_cv(stored, chance, pick);
                            gate_start = tick;
                        end
                    end
                    else if (TICK_W'(tick - gate_start) == TICK_W'(gate_len_cfg))
                    begin
                        r.gate = GATE_LOW;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arp_result_t got;
        arp_result_t want;
        if (!rst_n)
        begin
            chan_cfg       = RST_MIDI_CHANNEL;
            record_cfg     = RST_RECORD_MODE;
            gate_len_cfg   = RST_GATE_LENGTH;
            transpose_cfg  = RST_TRANSPOSE;
            low_cfg        = RST_LOW_NOTE;
            high_cfg       = RST_HIGH_NOTE;
            rnd_amount_cfg = RST_RANDOM_AMOUNT;
            fill           = '0;
            gate_start     = '0;
            expected_q.delete();
            errs           = 0;
            checked        = 0;
            cvs            = 0;
            error_count   <= 0;
            pending_count <= 0;
            checked_count <= 0;
            cv_count      <= 0;
        end
        else
        begin
            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MIDI_CHANNEL:  chan_cfg = cfg_data[CHAN_W-1:0];
                    CFG_RECORD_MODE:   record_cfg = cfg_data[0];
                    CFG_GATE_LENGTH:   gate_len_cfg = cfg_data[7:0];
                    CFG_TRANSPOSE:     transpose_cfg = cfg_data[5:0];
                    CFG_LOW_NOTE:      low_cfg = cfg_data[5:0];
                    CFG_HIGH_NOTE:     high_cfg = cfg_data[5:0];
                    CFG_RANDOM_AMOUNT: rnd_amount_cfg = cfg_data[2:0];
                    default:           ;
                endcase
            end

            // output transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.gate  = gate_action;
                got.cv_on = cv_valid;
                got.cv    = cv_value;
                if (expected_q.size() == 0)
                begin
                    errs++;
                    $error("unexpected result: gate_action %0d cv_valid %0d cv_value %0d",
                           got.gate, got.cv_on, got.cv);
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.cv_on)
                        cvs++;
                    if (got.gate !== want.gate)
                    begin
                        errs++;
                        $error("gate_action mismatch: expected %0d, actual %0d",
                               want.gate, got.gate);
                    end
                    if (got.cv_on !== want.cv_on)
                    begin
                        errs++;
                        $error("cv_valid mismatch: expected %0d, actual %0d",
                               want.cv_on, got.cv_on);
                    end
                    if (got.cv !== want.cv)
                    begin
                        errs++;
                        $error("cv_value mismatch: expected %0d, actual %0d",
                               want.cv, got.cv);
                    end
                end
            end

            // input transaction
            if (in_valid && !in_stall)
                expected_q.push_back(next_result(kind_t'(kind), event_channel, note,
                                                 tick_count, rand_chance, rand_pick));

            error_count   <= errs;
            pending_count <= expected_q.size();
            checked_count <= checked;
            cv_count      <= cvs;
        end
    end

endmodule

FILE: bench/midi_step_arpeggiator_tb.sv
`timescale 1ns / 1ps
// Testbench top for midi_step_arpeggiator: clock, reset, register setup, stimulus
// and verdict. Depends on msa_pkg, the block itself and msa_checker.
module midi_step_arpeggiator_tb;
    import msa_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RUN_LIMIT   = 1_000_000;
    localparam int ITEM_TARGET = 1050;
    localparam int SETTLE_WAIT = 30;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = KIND_NOTE_OFF;
    logic [CHAN_W-1:0]     event_channel = '0;
    logic [NOTE_W-1:0]     note = '0;
    logic [TICK_W-1:0]     tick_count = '0;
    logic [2:0]            rand_chance = '0;
    logic [2:0]            rand_pick = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            gate_action;
    logic                  cv_valid;
    logic [CV_W-1:0]       cv_value;

    int error_count;
    int pending_count;
    int checked_count;
    int cv_count;
    int items_sent = 0;
    int setups = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    midi_step_arpeggiator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .event_channel (event_channel),
        .note          (note),
        .tick_count    (tick_count),
        .rand_chance   (rand_chance),
        .rand_pick     (rand_pick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gate_action   (gate_action),
        .cv_valid      (cv_valid),
        .cv_value      (cv_value)
    );

    msa_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .event_channel (event_channel),
        .note          (note),
        .tick_count    (tick_count),
        .rand_chance   (rand_chance),
        .rand_pick     (rand_pick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gate_action   (gate_action),
        .cv_valid      (cv_valid),
        .cv_value      (cv_value),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .cv_count      (cv_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog
    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Mostly short idle runs, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [2:0] rnd3();
        return 3'($urandom_range(0, 7));
    endfunction

    // Receiver back-pressure
    initial
    begin
        int free_len;
        int stall_len;
        int r;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (quiet)
                free_len = 1;
            else if (r < 60)
                free_len = $urandom_range(1, 4);
            else if (r < 90)
                free_len = $urandom_range(5, 20);
            else
                free_len = $urandom_range(50, 150);
            out_stall <= 1'b0;
            repeat (free_len) @(posedge clk);
            if (!quiet)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    stall_len = $urandom_range(1, 3);
                else if (r < 93)
                    stall_len = $urandom_range(4, 12);
                else
                    stall_len = $urandom_range(30, 80);
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // One input transaction, held until accepted
    task automatic send(input kind_t k, input logic [CHAN_W-1:0] ch,
                        input logic [NOTE_W-1:0] pitch, input logic [TICK_W-1:0] tick,
                        input logic [2:0] chance, input logic [2:0] pick);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        event_channel <= ch;
        note          <= pitch;
        tick_count    <= tick;
        rand_chance   <= chance;
        rand_pick     <= pick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_noise();
        send(kind_t'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 31)),
             NOTE_W'($urandom_range(0, 127)), $urandom, rnd3(), rnd3());
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write all seven registers; block must be idle
    task automatic configure(input logic [CHAN_W-1:0] ch, input logic rec, input int gl,
                             input int tr, input int lo, input int hi, input int ra);
        write_reg(CFG_MIDI_CHANNEL, 8'(ch));
        write_reg(CFG_RECORD_MODE, 8'(rec));
        write_reg(CFG_GATE_LENGTH, 8'(gl));
        write_reg(CFG_TRANSPOSE, {2'b00, 6'(tr)});
        write_reg(CFG_LOW_NOTE, 8'(lo));
        write_reg(CFG_HIGH_NOTE, 8'(hi));
        write_reg(CFG_RANDOM_AMOUNT, 8'(ra));
        cfg_write <= 1'b0;
        @(posedge clk);
        setups++;
    endtask

    // Record a pattern, then play it back against a running tick count
    task automatic run_phase(input int idx);
        logic [CHAN_W-1:0] ch;
        logic [TICK_W-1:0] t;
        int gl, tr, lo, hi, ra, n, m, r;
        quiet = (idx % 5 == 3);
        if (idx == 0)
        begin
            ch = 5'd1; gl = 0; tr = -24; lo = 0; hi = 0; ra = 0;
        end
        else if (idx == 1)
        begin
            ch = 5'd16; gl = 255; tr = 24; lo = 60; hi = 61; ra = 6;
        end
        else
        begin
            r  = $urandom_range(0, 9);
            ch = (r == 0) ? 5'd1 : (r == 1) ? 5'd16 : CHAN_W'($urandom_range(1, 16));
            gl = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 255);
            tr = int'($urandom_range(0, 48)) - 24;
            lo = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20) : $urandom_range(0, 60);
            hi = ($urandom_range(0, 9) < 8) ? $urandom_range(lo, 61) : $urandom_range(0, 61);
            ra = $urandom_range(0, 6);
        end
        configure(ch, 1'b1, gl, tr, lo, hi, ra);

        // record segment, now and then overfilling the buffer
        send(KIND_CLEAR, ch, '0, '0, rnd3(), rnd3());
        n = ($urandom_range(0, 99) < 15) ? $urandom_range(16, 20) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send(KIND_NOTE_ON, ch, NOTE_W'($urandom_range(lo, 60)), $urandom,
                     rnd3(), rnd3());
        end
        settle();

        if (idx > 1)
        begin
            tr = int'($urandom_range(0, 48)) - 24;
            ra = $urandom_range(0, 6);
        end
        configure(ch, 1'b0, gl, tr, lo, hi, ra);

        // playback segment, sometimes across the tick wrap
        t = ($urandom_range(0, 99) < 15) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
        m = $urandom_range(30, 70);
        for (int i = 0; i < m; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                send(KIND_TICK, CHAN_W'($urandom_range(0, 31)), NOTE_W'($urandom_range(0, 127)),
                     t, rnd3(), rnd3());
                t = t + (($urandom_range(0, 99) < 85) ? 1 : $urandom_range(2, 13));
            end
            else if (r < 75)
                send(KIND_NOTE_ON, ch, NOTE_W'($urandom_range(0, 127)), $urandom,
                     rnd3(), rnd3());
            else if (r < 83)
                send(KIND_NOTE_OFF, ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 31))
                     : ch, NOTE_W'($urandom_range(0, 127)), $urandom, rnd3(), rnd3());
            else if (r < 86)
                send(KIND_CLEAR, ch, '0, $urandom, rnd3(), rnd3());
            else
                send_noise();
        end
        settle();
    endtask

    // Main sequence
    initial
    begin
        int phase;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: recording with every random jump enabled
        configure(5'd1, 1'b1, 3, -24, 0, 60, 6);
        send(KIND_NOTE_ON, 5'd1, 7'd0, '0, 3'd0, 3'd0);
        send(KIND_NOTE_ON, 5'd1, 7'd60, '0, 3'd5, 3'd4);
        send(KIND_NOTE_ON, 5'd1, 7'd30, '0, 3'd0, 3'd7);     // pick past the table
        send(KIND_NOTE_ON, 5'd1, 7'd45, '0, 3'd7, 3'd3);     // chance never below amount
        send(KIND_NOTE_ON, 5'd1, 7'd61, '0, 3'd0, 3'd0);     // above top note
        send(KIND_NOTE_ON, 5'd1, 7'd127, '0, 3'd0, 3'd0);
        send(KIND_NOTE_ON, 5'd16, 7'd30, '0, 3'd0, 3'd0);    // wrong channel
        send(KIND_NOTE_OFF, 5'd1, 7'd0, '0, 3'd0, 3'd0);
        send(KIND_NOTE_OFF, 5'd16, 7'd0, '0, 3'd0, 3'd0);
        send(KIND_TICK, 5'd1, 7'd0, 32'd0, 3'd0, 3'd0);      // ignored while recording
        settle();

        // directed: playback of the recorded notes, one below the low note
        configure(5'd16, 1'b0, 0, 24, 10, 61, 0);
        send(KIND_TICK, 5'd16, 7'd0, 32'd0, 3'd0, 3'd0);
        send(KIND_TICK, 5'd16, 7'd0, 32'd6, 3'd0, 3'd0);
        send(KIND_TICK, 5'd16, 7'd0, 32'd12, 3'd0, 3'd0);
        send(KIND_TICK, 5'd16, 7'd0, 32'd18, 3'd0, 3'd0);
        send(KIND_TICK, 5'd16, 7'd0, 32'hFFFF_FFFC, 3'd7, 3'd7);
        send(KIND_NOTE_ON, 5'd16, 7'd20, '0, 3'd0, 3'd0);    // played, not stored
        send(KIND_CLEAR, 5'd16, 7'd0, '0, 3'd0, 3'd0);
        send(KIND_TICK, 5'd16, 7'd0, 32'd24, 3'd0, 3'd0);    // empty buffer
        settle();

        // directed: gate-off after a step, including across the tick wrap
        configure(5'd1, 1'b1, 2, 0, 0, 60, 0);
        send(KIND_NOTE_ON, 5'd1, 7'd5, '0, 3'd0, 3'd0);
        send(KIND_NOTE_ON, 5'd1, 7'd9, '0, 3'd0, 3'd0);
        settle();
        configure(5'd1, 1'b0, 6, 0, 0, 60, 0);
        send(KIND_TICK, 5'd1, 7'd0, 32'hFFFF_FFFC, 3'd0, 3'd0);
        send(KIND_TICK, 5'd1, 7'd0, 32'd2, 3'd0, 3'd0);
        settle();

        // random record/playback phases
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phase);
            phase++;
        end
        quiet = 1'b0;
        settle();

        $display("Covered %0d input transactions over %0d register setups;", items_sent, setups);
        $display("%0d results compared, %0d of them with a CV word.", checked_count, cv_count);
        if (error_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/msa_pkg.sv
design/msa_divider.sv
design/msa_datapath.sv
design/msa_ctrl.sv
design/midi_step_arpeggiator.sv
design/msa_checker.sv
bench/msa_checker.sv
bench/midi_step_arpeggiator_tb.sv
